// ===== src/pulse_period_speed_estimator_top_macros.svh =====
// Assertion macros for the pulse period speed estimator.
// Depends on nothing; included by the top level only.
`ifndef PULSE_PERIOD_SPEED_ESTIMATOR_TOP_MACROS_SVH
`define PULSE_PERIOD_SPEED_ESTIMATOR_TOP_MACROS_SVH

// Check an overlapping implication on the block clock, off during reset.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on the block clock, off during reset.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pps_pkg.sv =====
// Shared types and constants of the pulse period speed estimator.
// Depends on nothing; used by the divider, the top level and the testbench.
package pps_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned STAMP_W = 24;

  localparam logic [1:0] OP_PULSE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_WRAP    = 2'd2;

  localparam logic [1:0] CFG_CALIBRATION = 2'd0;
  localparam logic [1:0] CFG_BOUNCE      = 2'd1;
  localparam logic [1:0] CFG_LIFETIME    = 2'd2;

  localparam logic [15:0] BOUNCE_RST   = 16'd62;
  localparam logic [7:0]  LIFETIME_RST = 8'd4;
  localparam int unsigned SPEED_STEP   = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_AVG,
    ST_DIV2,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/pps_in_if.sv =====
// Input channel of the speed estimator: valid, ready and one event.
// Depends on nothing.
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] stamp;
  logic        force_update;

  modport source (output valid, op, stamp, force_update, input ready);
  modport sink (input valid, op, stamp, force_update, output ready);
endinterface

// ===== src/pps_out_if.sv =====
// Output channel of the speed estimator: valid, ready and one result.
// Depends on nothing.
interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_value;
  logic        speed_changed;
  logic        pulses_valid;

  modport source (output valid, speed_value, speed_changed, pulses_valid, input ready);
  modport sink (input valid, speed_value, speed_changed, pulses_valid, output ready);
endinterface

// ===== src/pulse_period_speed_estimator_top.sv =====
// Top level of the pulse period speed estimator: sequencer, state, APB registers.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_div and the macros header.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------
//  in_if    | in  | op, stamp, force_update
//  out_if   | out | speed_value, speed_changed, pulses_valid
//  apb      | in  | calibration, bounce_ticks, lifetime_wraps
//
// Pulse, wrap, unused and stale-compute beats finish in the cycle they are taken.
// A fresh compute holds the input off, from one accept to the next, and runs no
// division with a zero period, else one or two of 16 steps each on the one shared
// divider. Input is held off while a compute is at work and while the output
// register is full and not being taken. Reset is asynchronous, active low, and
// clears all state but the working registers and the output beat's data.
`include "pulse_period_speed_estimator_top_macros.svh"

module pulse_period_speed_estimator_top #(
  parameter int unsigned SUM_COUNT   = 6,
  parameter int unsigned SLICE_SHIFT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pps_in_if.sink      in_if,
  pps_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned W      = pps_pkg::DATA_W;
  localparam int unsigned IDX_W  = $clog2(SUM_COUNT + 1);
  localparam int unsigned SEL_W  = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;

  // Configuration registers.
  logic [15:0] calib_q, bounce_q;
  logic [7:0]  life_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q  <= '0;
      bounce_q <= pps_pkg::BOUNCE_RST;
      life_q   <= pps_pkg::LIFETIME_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pps_pkg::CFG_CALIBRATION: calib_q  <= pwdata[15:0];
        pps_pkg::CFG_BOUNCE:      bounce_q <= pwdata[15:0];
        pps_pkg::CFG_LIFETIME:    life_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pps_pkg::CFG_CALIBRATION: prdata = {16'd0, calib_q};
      pps_pkg::CFG_BOUNCE:      prdata = {16'd0, bounce_q};
      pps_pkg::CFG_LIFETIME:    prdata = {24'd0, life_q};
      default:                  prdata = '0;
    endcase
  end

  // Estimator state.
  pps_pkg::state_e state_q, state_d;
  logic [23:0] newest_q, newest_d, older_q, older_d;
  logic        nstale_q, nstale_d, ostale_q, ostale_d;
  logic [7:0]  tally_q, tally_d, seen_q, seen_d;
  logic [W-1:0] sums_q [SUM_COUNT];
  logic [W-1:0] sums_d [SUM_COUNT];
  logic [W-1:0] shown_q, shown_d;
  logic        phase_q, phase_d;

  // Per-compute working registers.
  logic [W-1:0] raw_q, raw_d;
  logic        now_phase_q, now_phase_d, force_q, force_d;

  // Output register.
  logic        ov_q, ov_d, chg_q, chg_d, pv_q, pv_d;
  logic [W-1:0] spd_q, spd_d;

  // Shared divider.
  logic        div_start;
  logic [W-1:0] div_dsr, div_quo;
  pps_pkg::div_stat_t div_stat;

  pps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (calib_q),
    .divisor_i  (div_dsr),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  logic        in_fire, slot_free;
  logic [15:0] slice_in, slice_new, slice_old, spacing, age, bounce_d;
  logic [7:0]  upper, age_old, age_new;
  logic [IDX_W-1:0] idx;
  logic [SEL_W-1:0] sel;
  logic [W-1:0] avg;
  logic        minor_chg;

  assign slot_free   = !ov_q || out_if.ready;
  assign in_if.ready = (state_q == pps_pkg::ST_IDLE) && slot_free;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    slice_in  = in_if.stamp[SLICE_SHIFT +: 16];
    slice_new = newest_q[SLICE_SHIFT +: 16];
    slice_old = older_q[SLICE_SHIFT +: 16];
    spacing   = slice_new - slice_old;
    age       = slice_in - slice_new;
    bounce_d  = slice_in - slice_new;
    upper     = in_if.stamp[23:16];
    age_old   = upper - older_q[23:16];
    age_new   = upper - newest_q[23:16];

    // Average length from the raw speed: count thresholds 10, 20, 40, ...
    idx = '0;
    for (int j = 1; j <= SUM_COUNT; j++) begin
      if ({1'b0, raw_q} >= 17'(pps_pkg::SPEED_STEP << (j - 1))) idx = IDX_W'(j);
    end
    sel = SEL_W'(idx - 1'b1);
    avg = sums_q[sel] >> idx;

    minor_chg = (raw_q == shown_q) || ({1'b0, raw_q} == {1'b0, shown_q} + 17'd1) ||
                ({1'b0, shown_q} == {1'b0, raw_q} + 17'd1);
  end

  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    older_d     = older_q;
    nstale_d    = nstale_q;
    ostale_d    = ostale_q;
    tally_d     = tally_q;
    seen_d      = seen_q;
    sums_d      = sums_q;
    shown_d     = shown_q;
    phase_d     = phase_q;
    raw_d       = raw_q;
    now_phase_d = now_phase_q;
    force_d     = force_q;
    ov_d        = ov_q && !out_if.ready;
    chg_d       = chg_q;
    pv_d        = pv_q;
    spd_d       = spd_q;
    div_start   = 1'b0;
    div_dsr     = (spacing > age) ? spacing : age;

    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          ov_d  = 1'b1;
          chg_d = 1'b0;
          case (in_if.op)
            pps_pkg::OP_PULSE: begin
              if (bounce_d > bounce_q) begin
                tally_d  = tally_q + 8'd1;
                older_d  = newest_q;
                ostale_d = nstale_q;
                newest_d = in_if.stamp;
                nstale_d = 1'b0;
              end
            end
            pps_pkg::OP_WRAP: begin
              if (age_old > life_q) ostale_d = 1'b1;
              if (age_new > (life_q >> 1)) nstale_d = 1'b1;
            end
            pps_pkg::OP_COMPUTE: begin
              if (nstale_q || ostale_q) begin
                // Stale pulses: drop the history and show zero.
                for (int k = 0; k < SUM_COUNT; k++) sums_d[k] = '0;
                shown_d = '0;
                chg_d   = 1'b1;
              end else begin
                // Hold the result back until the divisions finish.
                ov_d        = 1'b0;
                now_phase_d = in_if.stamp[15];
                force_d     = in_if.force_update;
                if (tally_q != seen_q) begin
                  seen_d = tally_q;
                  for (int k = 0; k < SUM_COUNT; k++) begin
                    sums_d[k] = sums_q[k] - (sums_q[k] >> (k + 1)) + spacing;
                  end
                end
                if (div_dsr == '0) begin
                  raw_d   = '0;
                  state_d = pps_pkg::ST_AVG;
                end else begin
                  div_start = 1'b1;
                  state_d   = pps_pkg::ST_DIV1;
                end
              end
            end
            default: ;
          endcase
          pv_d  = !nstale_d && !ostale_d;
          spd_d = shown_d;
        end
      end
      pps_pkg::ST_DIV1: begin
        if (div_stat.done) begin
          raw_d   = div_quo;
          state_d = pps_pkg::ST_AVG;
        end
      end
      pps_pkg::ST_AVG: begin
        div_dsr = avg;
        if (idx != '0 && avg != '0) begin
          div_start = 1'b1;
          state_d   = pps_pkg::ST_DIV2;
        end else begin
          state_d = pps_pkg::ST_FIN;
        end
      end
      pps_pkg::ST_DIV2: begin
        div_dsr = avg;
        if (div_stat.done) begin
          raw_d   = div_quo;
          state_d = pps_pkg::ST_FIN;
        end
      end
      pps_pkg::ST_FIN: begin
        if (slot_free) begin
          ov_d  = 1'b1;
          chg_d = 1'b0;
          if (!minor_chg || now_phase_q != phase_q || force_q) begin
            phase_d = now_phase_q;
            shown_d = raw_q;
            chg_d   = 1'b1;
          end
          spd_d   = shown_d;
          pv_d    = !nstale_q && !ostale_q;
          state_d = pps_pkg::ST_IDLE;
        end
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pps_pkg::ST_IDLE;
      newest_q <= '0;
      older_q  <= '0;
      nstale_q <= 1'b1;
      ostale_q <= 1'b1;
      tally_q  <= '0;
      seen_q   <= '0;
      for (int k = 0; k < SUM_COUNT; k++) sums_q[k] <= '0;
      shown_q  <= '0;
      phase_q  <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      older_q  <= older_d;
      nstale_q <= nstale_d;
      ostale_q <= ostale_d;
      tally_q  <= tally_d;
      seen_q   <= seen_d;
      sums_q   <= sums_d;
      shown_q  <= shown_d;
      phase_q  <= phase_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q       <= raw_d;
    now_phase_q <= now_phase_d;
    force_q     <= force_d;
    chg_q       <= chg_d;
    pv_q        <= pv_d;
    spd_q       <= spd_d;
  end

  assign out_if.valid         = ov_q;
  assign out_if.speed_value   = spd_q;
  assign out_if.speed_changed = chg_q;
  assign out_if.pulses_valid  = pv_q;

  `PPS_ASSERT_NOW(a_busy_not_ready, state_q != pps_pkg::ST_IDLE, !in_if.ready, "ready while busy")
  `PPS_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `PPS_ASSERT_NEXT(a_div_leads_done, div_start, div_stat.busy, "divider did not start")
  `PPS_ASSERT_NOW(a_fin_no_div, state_q == pps_pkg::ST_FIN, !div_stat.busy, "finish before divide")
endmodule

// ===== src/pps_div.sv =====
// Restoring divider, one quotient bit a cycle, shared by both speed divisions.
// Depends on pps_pkg.
module pps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pps_pkg::DATA_W-1:0]  dividend_i,
  input  logic [pps_pkg::DATA_W-1:0]  divisor_i,
  output logic [pps_pkg::DATA_W-1:0]  quotient_o,
  output pps_pkg::div_stat_t          stat_o
);
  localparam int unsigned W   = pps_pkg::DATA_W;
  localparam int unsigned CW  = $clog2(W);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;
  logic          ge;

  always_comb begin
    trial  = {rem_q, quo_q[W-1]};
    ge     = trial >= {1'b0, dsr_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? W'(trial - {1'b0, dsr_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

// ===== test/tb_pulse_period_speed_estimator_top.sv =====
// Testbench of the pulse period speed estimator: directed table, then random event streams.
// Depends on pps_pkg, pps_in_if, pps_out_if and pulse_period_speed_estimator_top.
// Every output beat is checked field by field against a cycle-free predictor or a typed table entry.
module tb_pulse_period_speed_estimator_top;
  timeunit 1ns;
  timeprecision 1ps;

  // op value the block decodes as "no operation"
  localparam logic [1:0] OP_NONE = 2'd3;
  // cycles to let pass after the last beat, enough for a two-division compute
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned RANDOM_PHASE_ITEMS = 360;

  typedef struct packed {
    logic [15:0] speed_value;
    logic        speed_changed;
    logic        pulses_valid;
  } speed_res_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] stamp;
    logic        force_update;
    logic        typed;
    speed_res_t  res;
  } event_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  pps_in_if  in_if ();
  pps_out_if out_if ();

  pulse_period_speed_estimator_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the configuration and the estimator state.
  logic [15:0] calib_q;
  logic [15:0] bounce_q;
  logic [7:0]  lifetime_q;
  logic [23:0] newest_q, older_q;
  logic        newest_stale_q, older_stale_q;
  logic [7:0]  tally_q, tally_seen_q;
  logic [15:0] sums_q [6];
  logic [15:0] shown_q;
  logic        phase_q;

  speed_res_t  speed_expected [$];
  event_row_t  rows [$];
  int unsigned mismatches;
  bit          calm;   // drop random idling on both sides while set

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] slice_of(logic [23:0] t);
    return 16'(t >> 8);
  endfunction

  function automatic void predictor_reset();
    calib_q = '0;
    bounce_q = pps_pkg::BOUNCE_RST;
    lifetime_q = pps_pkg::LIFETIME_RST;
    newest_q = '0;
    older_q = '0;
    newest_stale_q = 1'b1;
    older_stale_q = 1'b1;
    tally_q = '0;
    tally_seen_q = '0;
    foreach (sums_q[k]) sums_q[k] = '0;
    shown_q = '0;
    phase_q = 1'b0;
  endfunction

  // Work out the shown speed after a compute; return 1 when it is rewritten.
  function automatic logic estimate_speed(logic [23:0] now, logic force_upd);
    logic [15:0] spacing, age, s, avg;
    logic [31:0] raw, n;
    int unsigned idx;
    int          diff;
    logic        phase;
    if (newest_stale_q || older_stale_q) begin
      foreach (sums_q[k]) sums_q[k] = '0;
      shown_q = '0;
      return 1'b1;
    end
    spacing = slice_of(newest_q) - slice_of(older_q);
    age = slice_of(now) - slice_of(newest_q);
    // fold the spacing into every rolling sum once per compute after a newly accepted pulse
    if (tally_seen_q != tally_q) begin
      tally_seen_q = tally_q;
      foreach (sums_q[k]) begin
        s = sums_q[k];
        s = s - (s >> (k + 1));
        sums_q[k] = s + spacing;
      end
    end
    if (spacing > age) raw = calib_q / spacing;
    else if (age == 0) raw = 0;
    else raw = calib_q / age;
    n = raw / pps_pkg::SPEED_STEP;
    if (n != 0) begin
      idx = 0;
      while (n != 0) begin
        n = n >> 1;
        idx++;
      end
      if (idx > 6) idx = 6;
      avg = sums_q[idx-1] >> idx;
      if (avg != 0) raw = calib_q / avg;
    end
    phase = now[15];
    diff = int'(raw) - int'(shown_q);
    if (diff < 2 && diff > -2 && phase == phase_q && !force_upd) return 1'b0;
    phase_q = phase;
    shown_q = raw[15:0];
    return 1'b1;
  endfunction

  function automatic speed_res_t predict_event(logic [1:0] op, logic [23:0] stamp,
                                               logic force_upd);
    speed_res_t  r;
    logic        changed;
    logic [15:0] d;
    logic [7:0]  upper, age_old, age_new;
    changed = 1'b0;
    case (op)
      pps_pkg::OP_PULSE: begin
        d = slice_of(stamp) - slice_of(newest_q);
        if (d > bounce_q) begin
          tally_q = tally_q + 8'd1;
          older_q = newest_q;
          older_stale_q = newest_stale_q;
          newest_q = stamp;
          newest_stale_q = 1'b0;
        end
      end
      pps_pkg::OP_COMPUTE: changed = estimate_speed(stamp, force_upd);
      pps_pkg::OP_WRAP: begin
        upper = stamp[23:16];
        age_old = upper - older_q[23:16];
        age_new = upper - newest_q[23:16];
        if (age_old > lifetime_q) older_stale_q = 1'b1;
        if (age_new > (lifetime_q >> 1)) newest_stale_q = 1'b1;
      end
      default: ;
    endcase
    r.speed_value = shown_q;
    r.speed_changed = changed;
    r.pulses_valid = !newest_stale_q && !older_stale_q;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [23:0] stamp, logic force_upd,
                                  logic typed = 1'b0, speed_res_t res = '0);
    event_row_t row;
    row.op = op;
    row.stamp = stamp;
    row.force_update = force_upd;
    row.typed = typed;
    row.res = res;
    rows.push_back(row);
  endfunction

  // Write one register through the APB port: setup, then access; called at negedge.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pps_pkg::CFG_CALIBRATION: calib_q = value[15:0];
      pps_pkg::CFG_BOUNCE:      bounce_q = value[15:0];
      pps_pkg::CFG_LIFETIME:    lifetime_q = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(logic [15:0] calib, logic [15:0] bounce, logic [7:0] life);
    write_reg(pps_pkg::CFG_CALIBRATION, 32'(calib));
    write_reg(pps_pkg::CFG_BOUNCE, 32'(bounce));
    write_reg(pps_pkg::CFG_LIFETIME, 32'(life));
  endtask

  // Hold until every expected beat has come back, then let the block settle.
  task automatic drain();
    while (speed_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Offer one event beat; called and returning at negedge.
  task automatic send_event(logic [1:0] op, logic [23:0] stamp, logic force_upd,
                            logic typed = 1'b0, speed_res_t res = '0);
    speed_res_t r;
    while (!calm && $urandom_range(99) < 32) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.op = op;
    in_if.stamp = stamp;
    in_if.force_update = force_upd;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_event(op, stamp, force_upd);
    speed_expected.push_back(typed ? res : r);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Stall the result side at random, except in calm stretches.
  always @(negedge clk_i) begin
    out_if.ready = calm || ($urandom_range(99) >= 32);
  end

  // Compare every taken result beat with the oldest expectation.
  always @(posedge clk_i) begin
    speed_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.speed_value = out_if.speed_value;
      got.speed_changed = out_if.speed_changed;
      got.pulses_valid = out_if.pulses_valid;
      if (speed_expected.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        mismatches++;
      end else begin
        want = speed_expected.pop_front();
        if (got.speed_value !== want.speed_value) begin
          $display("%0t: speed_value expected %0d actual %0d", $realtime,
                   want.speed_value, got.speed_value);
          mismatches++;
        end
        if (got.speed_changed !== want.speed_changed) begin
          $display("%0t: speed_changed expected %0b actual %0b", $realtime,
                   want.speed_changed, got.speed_changed);
          mismatches++;
        end
        if (got.pulses_valid !== want.pulses_valid) begin
          $display("%0t: pulses_valid expected %0b actual %0b", $realtime,
                   want.pulses_valid, got.pulses_valid);
          mismatches++;
        end
      end
    end
  end

  // Drive one phase of random traffic: mostly a wheel turning at a random rate
  // with computes and timer wraps in time order, some raw noise in between.
  task automatic random_phase(int unsigned items);
    logic [23:0] now, next_pulse;
    logic [23:0] period;
    int unsigned sent, pick;
    now = 24'($urandom);
    period = 24'($urandom_range(1, 60)) << 8;
    next_pulse = now + period;
    sent = 0;
    while (sent < items) begin
      calm = (sent >= items / 3) && (sent < items / 3 + 40);
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_event(2'($urandom), 24'($urandom), 1'($urandom));
      end else if (pick < 12) begin
        // new wheel rate: from very fast to slow, now and then a long pause
        period = ($urandom_range(3) == 0) ? 24'($urandom_range(1, 4000)) << 8
                                          : 24'($urandom_range(1, 80)) << 8;
        if ($urandom_range(9) == 0) now = now + 24'($urandom_range(1, 40)) * 24'h10000;
        send_event(pps_pkg::OP_WRAP, now, 1'($urandom));
      end else begin
        now = now + 24'($urandom_range(1, period / 3 + 1));
        if (now - next_pulse < 24'h800000) begin
          // jitter the pulse a little, sometimes a bounce right after it
          send_event(pps_pkg::OP_PULSE, now, 1'($urandom));
          if ($urandom_range(7) == 0) begin
            send_event(pps_pkg::OP_PULSE, now + (24'($urandom_range(0, 255)) << 4),
                       1'($urandom));
            sent++;
          end
          next_pulse = now + period + 24'($urandom_range(0, 255));
        end else if ($urandom_range(5) == 0) begin
          send_event(pps_pkg::OP_WRAP, now, 1'($urandom));
        end else begin
          send_event(pps_pkg::OP_COMPUTE, now, $urandom_range(7) == 0);
        end
      end
      sent++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = pps_pkg::OP_PULSE;
    in_if.stamp = '0;
    in_if.force_update = 1'b0;
    mismatches = 0;
    calm = 1'b0;
    predictor_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, reset configuration: stale compute, unused op, bounce, fresh pair.
    add_row(pps_pkg::OP_COMPUTE, 24'h000000, 1'b0, 1'b1, '{16'd0, 1'b1, 1'b0});
    add_row(OP_NONE,             24'hFFFFFF, 1'b1, 1'b1, '{16'd0, 1'b0, 1'b0});
    add_row(pps_pkg::OP_PULSE,   24'h000100, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b0});
    add_row(pps_pkg::OP_PULSE,   24'h004000, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b0});
    add_row(pps_pkg::OP_PULSE,   24'h008000, 1'b0, 1'b1, '{16'd0, 1'b0, 1'b1});
    add_row(pps_pkg::OP_COMPUTE, 24'h008100, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h008200, 1'b1);
    foreach (rows[i]) send_event(rows[i].op, rows[i].stamp, rows[i].force_update,
                                 rows[i].typed, rows[i].res);
    drain();

    // Full-scale calibration, no debounce, longest lifetime: very fast wheel
    // drives the average index into its clamp, then wraps age the pulses out.
    set_config(16'hFFFF, 16'h0000, 8'hFF);
    rows.delete();
    add_row(pps_pkg::OP_PULSE,   24'h010000, 1'b0);
    add_row(pps_pkg::OP_PULSE,   24'h010100, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h010180, 1'b0);
    add_row(pps_pkg::OP_PULSE,   24'h010200, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h010200, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h010280, 1'b1);
    add_row(pps_pkg::OP_PULSE,   24'hFFFF00, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'hFFFFFF, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h0000FF, 1'b1);
    add_row(pps_pkg::OP_WRAP,    24'h7F0000, 1'b0);
    add_row(pps_pkg::OP_WRAP,    24'h800000, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'h800000, 1'b0);
    add_row(pps_pkg::OP_WRAP,    24'hFF0000, 1'b0);
    add_row(pps_pkg::OP_COMPUTE, 24'hFF0001, 1'b0);
    foreach (rows[i]) send_event(rows[i].op, rows[i].stamp, rows[i].force_update,
                                 rows[i].typed, rows[i].res);
    drain();

    // Random part over several settings, the extremes among them.
    set_config(16'd60000, 16'd2, 8'd4);
    random_phase(RANDOM_PHASE_ITEMS);
    drain();
    set_config(16'h0000, 16'hFFFF, 8'h00);
    random_phase(RANDOM_PHASE_ITEMS / 2);
    drain();
    set_config(16'hFFFF, 16'h0000, 8'hFF);
    random_phase(RANDOM_PHASE_ITEMS);
    drain();
    set_config(16'd3000, 16'd0, 8'd1);
    random_phase(RANDOM_PHASE_ITEMS);
    drain();
    set_config(16'($urandom), 16'($urandom_range(0, 40)), 8'($urandom_range(2, 20)));
    random_phase(RANDOM_PHASE_ITEMS);
    drain();
    set_config(16'($urandom), 16'($urandom), 8'($urandom));
    random_phase(RANDOM_PHASE_ITEMS / 2);
    drain();

    if (mismatches == 0 && speed_expected.size() == 0) begin
      $display("** pulse_period_speed_estimator_top: PASSED **");
    end else begin
      $display("** pulse_period_speed_estimator_top: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #50ms;
    $display("** pulse_period_speed_estimator_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pps_pkg.sv
src/pps_in_if.sv
src/pps_out_if.sv
src/pps_div.sv
src/pulse_period_speed_estimator_top.sv
test/tb_pulse_period_speed_estimator_top.sv
